// ----- rtl/gn3_pkg.sv -----
// ----------------------------------------------------------------------------
// gn3_pkg
// Shared constants, command codes, controller states and the command word
// that the controller sends to the datapath of the gradient noise unit.
// ----------------------------------------------------------------------------
package gn3_pkg;

   // Table size and fixed-point format of the coordinates.
   localparam int TABLE_BITS  = 8;
   localparam int TABLE_SIZE  = 1 << TABLE_BITS;
   localparam int FRAC_BITS   = 16;
   localparam int MAX_OCTAVES = 8;
   localparam int GRAD_FRAC   = 14;

   localparam int COORD_W = TABLE_BITS + FRAC_BITS;
   localparam int GRAD_W  = 16;
   localparam int PERM_W  = TABLE_BITS;
   localparam int OUT_W   = FRAC_BITS + 2;
   localparam int OCT_W   = 4;

   // Corner offset, dot-product terms and blended values.
   localparam int D_W    = FRAC_BITS + 2;
   localparam int PROD_W = GRAD_W + D_W;
   localparam int SUM_W  = PROD_W + 2;
   localparam int V_W    = SUM_W - GRAD_FRAC;
   localparam int S_W    = FRAC_BITS + 1;
   localparam int LP_W   = V_W + 1 + S_W + 1;
   localparam int QUEUE_DEPTH = 8;
   localparam int QP_W   = $clog2(QUEUE_DEPTH) + 1;

   // Octave weighting and accumulation.
   localparam int SH_W  = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
   localparam int ACC_W = V_W + MAX_OCTAVES + 3;
   localparam logic signed [ACC_W-1:0] ACC_OUT_MAX =
      ACC_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
   localparam logic signed [ACC_W-1:0] ACC_OUT_MIN = -ACC_OUT_MAX - ACC_W'(1);

   // Gather cycles: eight corner reads plus the read and multiply latency.
   localparam int CORNERS   = 8;
   localparam int GRAD_LAST = CORNERS + 1;
   localparam int CNT_W     = $clog2(GRAD_LAST + 1);
   localparam int LERPS     = 7;
   localparam int LERP_W    = $clog2(LERPS);

   // Axis codes.
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   typedef enum logic [2:0] {
      CMD_LOAD_X    = 3'd0,
      CMD_LOAD_Y    = 3'd1,
      CMD_LOAD_Z    = 3'd2,
      CMD_LOAD_GRAD = 3'd3,
      CMD_NOISE     = 3'd4,
      CMD_TURB      = 3'd5
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PERM_A,
      ST_PERM_B,
      ST_PERM_C,
      ST_GRAD,
      ST_LERP_A,
      ST_LERP_B,
      ST_ACCUM,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic       wr_x;
      logic       wr_y;
      logic       wr_z;
      logic       wr_g;
      logic       capture;
      logic       turb;
      logic       perm_hi;
      logic       perm_lat0;
      logic       perm_lat1;
      logic       grad_rd;
      logic [2:0] corner;
      logic       sm_go;
      logic [1:0] sm_axis;
      logic       lerp_a;
      logic       lerp_b;
      logic [1:0] lerp_axis;
      logic       accum;
      logic       rsp;
   } ctl_type;

endpackage

// ----- rtl/gn3_ram.sv -----
// ----------------------------------------------------------------------------
// gn3_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module gn3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/gn3_ctrl.sv -----
// ----------------------------------------------------------------------------
// gn3_ctrl
// Sequencer for the noise unit: table loads, and per octave the permutation
// reads, corner gather, seven blends and the accumulation.
// ----------------------------------------------------------------------------
module gn3_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [2:0]              cmd,
   input  logic [gn3_pkg::OCT_W-1:0] octaves,
   output logic                    busy,
   output gn3_pkg::ctl_type        ctl
);

   gn3_pkg::state_type state_ff, state_in;
   logic [gn3_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [gn3_pkg::LERP_W-1:0] lerp_ff, lerp_in;
   logic [gn3_pkg::OCT_W-1:0]  oct_ff, oct_in;
   logic                       is_query;
   logic [gn3_pkg::OCT_W-1:0]  oct_first;

   // A query runs one octave for noise, a clamped count for turbulence.
   always_comb begin
      is_query = (cmd == gn3_pkg::CMD_NOISE) || (cmd == gn3_pkg::CMD_TURB);
      if (cmd == gn3_pkg::CMD_TURB) begin
         if (octaves > gn3_pkg::OCT_W'(gn3_pkg::MAX_OCTAVES)) begin
            oct_first = gn3_pkg::OCT_W'(gn3_pkg::MAX_OCTAVES);
         end else begin
            oct_first = octaves;
         end
      end else begin
         oct_first = gn3_pkg::OCT_W'(1);
      end
   end

   // Next state and loop counters.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      lerp_in  = lerp_ff;
      oct_in   = oct_ff;
      unique case (state_ff)
         gn3_pkg::ST_IDLE: begin
            if (start && is_query) begin
               oct_in = oct_first;
               if (oct_first == '0) begin
                  state_in = gn3_pkg::ST_DONE;
               end else begin
                  state_in = gn3_pkg::ST_PERM_A;
               end
            end
         end
         gn3_pkg::ST_PERM_A: state_in = gn3_pkg::ST_PERM_B;
         gn3_pkg::ST_PERM_B: state_in = gn3_pkg::ST_PERM_C;
         gn3_pkg::ST_PERM_C: begin
            state_in = gn3_pkg::ST_GRAD;
            cnt_in   = '0;
         end
         gn3_pkg::ST_GRAD: begin
            cnt_in = cnt_ff + gn3_pkg::CNT_W'(1);
            if (cnt_ff == gn3_pkg::CNT_W'(gn3_pkg::GRAD_LAST)) begin
               state_in = gn3_pkg::ST_LERP_A;
               lerp_in  = '0;
            end
         end
         gn3_pkg::ST_LERP_A: state_in = gn3_pkg::ST_LERP_B;
         gn3_pkg::ST_LERP_B: begin
            lerp_in = lerp_ff + gn3_pkg::LERP_W'(1);
            if (lerp_ff == gn3_pkg::LERP_W'(gn3_pkg::LERPS - 1)) begin
               state_in = gn3_pkg::ST_ACCUM;
            end else begin
               state_in = gn3_pkg::ST_LERP_A;
            end
         end
         gn3_pkg::ST_ACCUM: begin
            oct_in = oct_ff - gn3_pkg::OCT_W'(1);
            if (oct_ff == gn3_pkg::OCT_W'(1)) begin
               state_in = gn3_pkg::ST_DONE;
            end else begin
               state_in = gn3_pkg::ST_PERM_A;
            end
         end
         gn3_pkg::ST_DONE: state_in = gn3_pkg::ST_IDLE;
         default: state_in = gn3_pkg::ST_IDLE;
      endcase
   end

   // Command word for the datapath.
   always_comb begin
      ctl = '0;
      unique case (state_ff)
         gn3_pkg::ST_IDLE: begin
            ctl.wr_x    = start && (cmd == gn3_pkg::CMD_LOAD_X);
            ctl.wr_y    = start && (cmd == gn3_pkg::CMD_LOAD_Y);
            ctl.wr_z    = start && (cmd == gn3_pkg::CMD_LOAD_Z);
            ctl.wr_g    = start && (cmd == gn3_pkg::CMD_LOAD_GRAD);
            ctl.capture = start && is_query;
            ctl.turb    = (cmd == gn3_pkg::CMD_TURB);
         end
         gn3_pkg::ST_PERM_A: ctl.perm_hi = 1'b0;
         gn3_pkg::ST_PERM_B: begin
            ctl.perm_hi   = 1'b1;
            ctl.perm_lat0 = 1'b1;
         end
         gn3_pkg::ST_PERM_C: ctl.perm_lat1 = 1'b1;
         gn3_pkg::ST_GRAD: begin
            ctl.grad_rd = (cnt_ff < gn3_pkg::CNT_W'(gn3_pkg::CORNERS));
            ctl.corner  = cnt_ff[2:0];
            ctl.sm_go   = (cnt_ff < gn3_pkg::CNT_W'(3));
            ctl.sm_axis = cnt_ff[1:0];
         end
         gn3_pkg::ST_LERP_A: begin
            ctl.lerp_a = 1'b1;
            if (lerp_ff < gn3_pkg::LERP_W'(4)) begin
               ctl.lerp_axis = gn3_pkg::AXIS_Z;
            end else if (lerp_ff < gn3_pkg::LERP_W'(6)) begin
               ctl.lerp_axis = gn3_pkg::AXIS_Y;
            end else begin
               ctl.lerp_axis = gn3_pkg::AXIS_X;
            end
         end
         gn3_pkg::ST_LERP_B: ctl.lerp_b = 1'b1;
         gn3_pkg::ST_ACCUM:  ctl.accum  = 1'b1;
         gn3_pkg::ST_DONE:   ctl.rsp    = 1'b1;
         default: ctl = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gn3_pkg::ST_IDLE;
         cnt_ff   <= '0;
         lerp_ff  <= '0;
         oct_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         lerp_ff  <= lerp_in;
         oct_ff   <= oct_in;
      end
   end

   assign busy = (state_ff != gn3_pkg::ST_IDLE);

endmodule

// ----- rtl/gn3_dp.sv -----
// ----------------------------------------------------------------------------
// gn3_dp
// Datapath of the noise unit: table RAMs, smoothstep unit, corner dot
// products, blend queue with a shared blend multiplier, and the accumulator.
// ----------------------------------------------------------------------------
module gn3_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  gn3_pkg::ctl_type                    ctl,
   input  logic [gn3_pkg::TABLE_BITS-1:0]      req_table_index,
   input  logic [gn3_pkg::PERM_W-1:0]          req_perm_value,
   input  logic signed [gn3_pkg::GRAD_W-1:0]   req_grad_x,
   input  logic signed [gn3_pkg::GRAD_W-1:0]   req_grad_y,
   input  logic signed [gn3_pkg::GRAD_W-1:0]   req_grad_z,
   input  logic [gn3_pkg::COORD_W-1:0]         req_coord_x,
   input  logic [gn3_pkg::COORD_W-1:0]         req_coord_y,
   input  logic [gn3_pkg::COORD_W-1:0]         req_coord_z,
   output logic signed [gn3_pkg::OUT_W-1:0]    rsp_noise_value
);

   localparam int F  = gn3_pkg::FRAC_BITS;
   localparam int TB = gn3_pkg::TABLE_BITS;

   logic [gn3_pkg::COORD_W-1:0]      co_ff [3];
   logic                             turb_ff;
   logic [gn3_pkg::SH_W-1:0]         sh_ff;
   logic signed [gn3_pkg::ACC_W-1:0] acc_ff;
   logic [gn3_pkg::PERM_W-1:0]       p_ff [3][2];
   logic [gn3_pkg::PERM_W-1:0]       prd [3];
   logic [3*gn3_pkg::GRAD_W-1:0]     grd;
   logic [TB-1:0]                    perm_addr [3];
   logic [TB-1:0]                    gaddr;

   // Load writes and the permutation reads of the current cell.
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         perm_addr[a] = co_ff[a][gn3_pkg::COORD_W-1:F] + TB'(ctl.perm_hi);
      end
   end

   gn3_ram #(.WIDTH(gn3_pkg::PERM_W), .DEPTH(gn3_pkg::TABLE_SIZE)) u_perm_x (
      .clock(clock), .we(ctl.wr_x), .waddr(req_table_index), .wdata(req_perm_value),
      .raddr(perm_addr[0]), .rdata(prd[0])
   );

   gn3_ram #(.WIDTH(gn3_pkg::PERM_W), .DEPTH(gn3_pkg::TABLE_SIZE)) u_perm_y (
      .clock(clock), .we(ctl.wr_y), .waddr(req_table_index), .wdata(req_perm_value),
      .raddr(perm_addr[1]), .rdata(prd[1])
   );

   gn3_ram #(.WIDTH(gn3_pkg::PERM_W), .DEPTH(gn3_pkg::TABLE_SIZE)) u_perm_z (
      .clock(clock), .we(ctl.wr_z), .waddr(req_table_index), .wdata(req_perm_value),
      .raddr(perm_addr[2]), .rdata(prd[2])
   );

   gn3_ram #(.WIDTH(3 * gn3_pkg::GRAD_W), .DEPTH(gn3_pkg::TABLE_SIZE)) u_grad (
      .clock(clock), .we(ctl.wr_g), .waddr(req_table_index),
      .wdata({req_grad_x, req_grad_y, req_grad_z}),
      .raddr(gaddr), .rdata(grd)
   );

   // The gradient of a corner is picked by XOR of its three permutation entries.
   assign gaddr = p_ff[0][ctl.corner[2]] ^ p_ff[1][ctl.corner[1]] ^ p_ff[2][ctl.corner[0]];

   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         if (ctl.perm_lat0) begin
            p_ff[a][0] <= prd[a];
         end
         if (ctl.perm_lat1) begin
            p_ff[a][1] <= prd[a];
         end
      end
   end

   // Smoothstep unit: square in the first stage, times (3 - 2t) in the second.
   logic [F-1:0]               sm_t_ff;
   logic [F-1:0]               t2_ff;
   logic [1:0]                 sm_ax_ff;
   logic                       sm_vld_ff;
   logic [gn3_pkg::S_W-1:0]    s_ff [3];
   logic [F-1:0]               sm_t_in;
   logic [2*F-1:0]             sq;
   logic [F+1:0]               kval;
   logic [2*F+1:0]             sprod;

   always_comb begin
      unique case (ctl.sm_axis)
         gn3_pkg::AXIS_X: sm_t_in = co_ff[0][F-1:0];
         gn3_pkg::AXIS_Y: sm_t_in = co_ff[1][F-1:0];
         default:         sm_t_in = co_ff[2][F-1:0];
      endcase
      sq    = sm_t_in * sm_t_in;
      kval  = (F+2)'(3) << F;
      kval  = kval - {1'b0, sm_t_ff, 1'b0};
      sprod = t2_ff * kval;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sm_vld_ff <= 1'b0;
      end else begin
         sm_vld_ff <= ctl.sm_go;
      end
      sm_t_ff  <= sm_t_in;
      t2_ff    <= sq[2*F-1:F];
      sm_ax_ff <= ctl.sm_axis;
      if (sm_vld_ff) begin
         s_ff[sm_ax_ff] <= sprod[F+gn3_pkg::S_W-1:F];
      end
   end

   // Corner dot products: read, three products, then the floored sum.
   logic                              rd_vld_ff, mul_vld_ff;
   logic [2:0]                        rd_idx_ff;
   logic signed [gn3_pkg::PROD_W-1:0] prod_ff [3];
   logic signed [gn3_pkg::D_W-1:0]    dlt [3];
   logic signed [gn3_pkg::GRAD_W-1:0] gcomp [3];
   logic signed [gn3_pkg::SUM_W-1:0]  dsum;
   logic signed [gn3_pkg::V_W-1:0]    corner_val;

   always_comb begin
      gcomp[0] = grd[3*gn3_pkg::GRAD_W-1:2*gn3_pkg::GRAD_W];
      gcomp[1] = grd[2*gn3_pkg::GRAD_W-1:gn3_pkg::GRAD_W];
      gcomp[2] = grd[gn3_pkg::GRAD_W-1:0];
      for (int a = 0; a < 3; a++) begin
         dlt[a] = $signed({2'b00, co_ff[a][F-1:0]})
                - $signed({1'b0, rd_idx_ff[2-a], {F{1'b0}}});
      end
      dsum = gn3_pkg::SUM_W'(prod_ff[0]) + gn3_pkg::SUM_W'(prod_ff[1])
           + gn3_pkg::SUM_W'(prod_ff[2]);
      corner_val = dsum[gn3_pkg::SUM_W-1:gn3_pkg::GRAD_FRAC];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff  <= 1'b0;
         mul_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff  <= ctl.grad_rd;
         mul_vld_ff <= rd_vld_ff;
      end
      rd_idx_ff <= ctl.corner;
      for (int a = 0; a < 3; a++) begin
         prod_ff[a] <= gcomp[a] * dlt[a];
      end
   end

   // Blend queue: corners are appended in order, each blend pops the two
   // oldest values and appends the blended one.
   logic signed [gn3_pkg::V_W-1:0]     q_ff [gn3_pkg::QUEUE_DEPTH];
   logic [gn3_pkg::QP_W-1:0]           wp_ff;
   logic signed [gn3_pkg::V_W-1:0]     a_ff;
   logic signed [gn3_pkg::LP_W-1:0]    lprod_ff;
   logic signed [gn3_pkg::V_W:0]       diff;
   logic [gn3_pkg::S_W-1:0]            s_sel;
   logic signed [gn3_pkg::LP_W-F-1:0]  lsum;
   logic                               push;
   logic signed [gn3_pkg::V_W-1:0]     push_val;

   always_comb begin
      unique case (ctl.lerp_axis)
         gn3_pkg::AXIS_X: s_sel = s_ff[0];
         gn3_pkg::AXIS_Y: s_sel = s_ff[1];
         default:         s_sel = s_ff[2];
      endcase
      diff = (gn3_pkg::V_W+1)'(q_ff[1]) - (gn3_pkg::V_W+1)'(q_ff[0]);
      lsum = (gn3_pkg::LP_W-F)'(a_ff) + lprod_ff[gn3_pkg::LP_W-1:F];
      push = mul_vld_ff || ctl.lerp_b;
      push_val = ctl.lerp_b ? lsum[gn3_pkg::V_W-1:0] : corner_val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
      end else if (ctl.capture || ctl.accum) begin
         wp_ff <= '0;
      end else if (ctl.lerp_a) begin
         wp_ff <= wp_ff - gn3_pkg::QP_W'(2);
      end else if (push) begin
         wp_ff <= wp_ff + gn3_pkg::QP_W'(1);
      end
      if (ctl.lerp_a) begin
         for (int n = 0; n < gn3_pkg::QUEUE_DEPTH - 2; n++) begin
            q_ff[n] <= q_ff[n+2];
         end
         a_ff     <= q_ff[0];
         lprod_ff <= diff * $signed({1'b0, s_sel});
      end else if (push) begin
         q_ff[wp_ff[gn3_pkg::QP_W-2:0]] <= push_val;
      end
   end

   // Octave accumulation; the coordinates double after every octave.
   logic signed [gn3_pkg::ACC_W-1:0] weighted;

   assign weighted = gn3_pkg::ACC_W'(q_ff[0]) <<< sh_ff;

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         co_ff[0] <= req_coord_x;
         co_ff[1] <= req_coord_y;
         co_ff[2] <= req_coord_z;
         turb_ff  <= ctl.turb;
         sh_ff    <= gn3_pkg::SH_W'(gn3_pkg::MAX_OCTAVES - 1);
         acc_ff   <= '0;
      end else if (ctl.accum) begin
         for (int a = 0; a < 3; a++) begin
            co_ff[a] <= co_ff[a] << 1;
         end
         sh_ff  <= sh_ff - gn3_pkg::SH_W'(1);
         acc_ff <= acc_ff + weighted;
      end
   end

   // Result: saturated noise, or the saturated magnitude of the octave sum.
   logic signed [gn3_pkg::ACC_W-1:0] mag, scaled, res;

   always_comb begin
      mag = (acc_ff < 0) ? -acc_ff : acc_ff;
      if (turb_ff) begin
         scaled = mag >>> (gn3_pkg::MAX_OCTAVES - 1);
         res = (scaled > gn3_pkg::ACC_OUT_MAX) ? gn3_pkg::ACC_OUT_MAX : scaled;
      end else begin
         scaled = acc_ff >>> (gn3_pkg::MAX_OCTAVES - 1);
         priority if (scaled > gn3_pkg::ACC_OUT_MAX) begin
            res = gn3_pkg::ACC_OUT_MAX;
         end else if (scaled < gn3_pkg::ACC_OUT_MIN) begin
            res = gn3_pkg::ACC_OUT_MIN;
         end else begin
            res = scaled;
         end
      end
      rsp_noise_value = res[gn3_pkg::OUT_W-1:0];
   end

endmodule

// ----- rtl/gradient_noise_3d_unit.sv -----
// ----------------------------------------------------------------------------
// gradient_noise_3d_unit
// Three-dimensional gradient noise with turbulence, in fixed point.
// ----------------------------------------------------------------------------
// Usage:
// A word is offered on the req_ ports with start high; it is taken at a
// clock edge where busy is low. Load words (x, y, z permutation entry or
// gradient vector) are written at that edge, keep busy low and give no
// result. Unknown command codes are ignored.
// A noise or turbulence query raises busy. Each octave runs the permutation
// RAM reads, then the eight gradient RAM reads and the dot-product pipeline,
// then the seven blends through the single blend multiplier, and then the
// accumulation. The result word is shown on rsp_noise_value with rsp_valid
// high for one cycle once the last octave is accumulated (noise runs one
// octave); a turbulence query with zero octaves answers in the next cycle.
// busy falls after the result cycle, so one query is worked on at a time.
// The receiver cannot stall; the result is taken in its strobe cycle.
// Reset clears the sequencer; the tables are undefined until loaded.
// ----------------------------------------------------------------------------
module gradient_noise_3d_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [2:0]                        req_cmd,
   input  logic [gn3_pkg::TABLE_BITS-1:0]    req_table_index,
   input  logic [gn3_pkg::PERM_W-1:0]        req_perm_value,
   input  logic signed [gn3_pkg::GRAD_W-1:0] req_grad_x,
   input  logic signed [gn3_pkg::GRAD_W-1:0] req_grad_y,
   input  logic signed [gn3_pkg::GRAD_W-1:0] req_grad_z,
   input  logic [gn3_pkg::COORD_W-1:0]       req_coord_x,
   input  logic [gn3_pkg::COORD_W-1:0]       req_coord_y,
   input  logic [gn3_pkg::COORD_W-1:0]       req_coord_z,
   input  logic [gn3_pkg::OCT_W-1:0]         req_octaves,
   output logic                              rsp_valid,
   output logic signed [gn3_pkg::OUT_W-1:0]  rsp_noise_value
);

   gn3_pkg::ctl_type ctl;

   // Sequencer.
   gn3_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .cmd     (req_cmd),
      .octaves (req_octaves),
      .busy    (busy),
      .ctl     (ctl)
   );

   // Tables and arithmetic.
   gn3_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .req_table_index (req_table_index),
      .req_perm_value  (req_perm_value),
      .req_grad_x      (req_grad_x),
      .req_grad_y      (req_grad_y),
      .req_grad_z      (req_grad_z),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .req_coord_z     (req_coord_z),
      .rsp_noise_value (rsp_noise_value)
   );

   assign rsp_valid = ctl.rsp;

`ifndef SYNTHESIS
   // A result strobe lasts a single cycle.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // A result only appears while a query is in progress.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy)
      else $error("result strobe outside a query");

   // An accepted query makes the unit busy.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_cmd == gn3_pkg::CMD_NOISE || req_cmd == gn3_pkg::CMD_TURB))
      |=> busy)
      else $error("query accepted without going busy");

   // Table loads never start a query.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_cmd == gn3_pkg::CMD_LOAD_X || req_cmd == gn3_pkg::CMD_LOAD_Y
       || req_cmd == gn3_pkg::CMD_LOAD_Z || req_cmd == gn3_pkg::CMD_LOAD_GRAD))
      |=> !busy)
      else $error("table load made the unit busy");
`endif

endmodule
